// File: design/swrmf_pkg.sv
// Package for the shallow-water Rusanov mass flux block.
// Holds fixed field widths and the gravity reset value; no dependencies.
package swrmf_pkg;
    localparam int unsigned VEL_W  = 32;
    localparam int unsigned GRAV_W = 24;
    localparam int unsigned FLUX_W = 48;
    localparam logic [GRAV_W-1:0] GRAV_RESET = 24'd642908;
endpackage

// File: design/swrmf_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Uses swrmf_pkg; instantiated by shallow_water_rusanov_mass_flux.
module swrmf_isqrt
    import swrmf_pkg::*;
#(
    parameter int unsigned IN_W = 56
) (
    input  logic                  i_clk,
    input  logic [IN_W-1:0]       i_rad,
    output logic [(IN_W/2)-1:0]   o_root
);
    localparam int unsigned N = IN_W / 2;

    logic [IN_W-1:0] r_rem  [N+1];
    logic [IN_W-1:0] r_rad  [N+1];
    logic [N-1:0]    r_root [N+1];

    always_comb begin
        r_rem[0]  = '0;
        r_rad[0]  = i_rad;
        r_root[0] = '0;
    end

    for (genvar k = 0; k < N; k++) begin : g_st
        logic [IN_W+1:0] n_trial;
        logic [IN_W+1:0] n_cur;
        logic [IN_W-1:0] q_rem;
        logic [IN_W-1:0] q_rad;
        logic [N-1:0]    q_root;
        always_comb begin
            n_cur   = {r_rem[k], r_rad[k][IN_W-1 -: 2]};
            n_trial = n_cur - {{(IN_W-N){1'b0}}, r_root[k], 2'b01};
        end
        always_ff @(posedge i_clk) begin
            q_rad  <= r_rad[k] << 2;
            if (!n_trial[IN_W+1]) begin
                q_rem  <= n_trial[IN_W-1:0];
                q_root <= {r_root[k][N-2:0], 1'b1};
            end else begin
                q_rem  <= n_cur[IN_W-1:0];
                q_root <= {r_root[k][N-2:0], 1'b0};
            end
        end
        always_comb begin
            r_rem[k+1]  = q_rem;
            r_rad[k+1]  = q_rad;
            r_root[k+1] = q_root;
        end
    end

    assign o_root = r_root[N];
endmodule

// File: design/shallow_water_rusanov_mass_flux.sv
// Top level: Rusanov mass flux at one shallow-water interface.
// Uses swrmf_pkg and swrmf_isqrt.
//
//  channel | ports                                         | handshake
//  input   | i_vel_left i_vel_right i_depth_left/right     | i_start & !o_busy
//  config  | i_cfg_we i_cfg_wdata (gravity)                | i_cfg_we
//  result  | o_mass_flux o_saturated                       | o_done strobe
//
// One item per cycle; the pipeline holds one stage per root bit plus six arithmetic stages.
// o_busy is always low: every stage advances each cycle and the receiver cannot stall.
// Synchronous active-low reset clears the valid chain and loads gravity with GRAV_RESET.
module shallow_water_rusanov_mass_flux
    import swrmf_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic                     i_cfg_we,
    input  logic [GRAV_W-1:0]        i_cfg_wdata,
    input  logic signed [VEL_W-1:0]  i_vel_left,
    input  logic signed [VEL_W-1:0]  i_vel_right,
    input  logic signed [VEL_W-1:0]  i_depth_left,
    input  logic signed [VEL_W-1:0]  i_depth_right,
    output logic                     o_done,
    output logic signed [FLUX_W-1:0] o_mass_flux,
    output logic                     o_saturated
);
    localparam int unsigned SQL   = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int unsigned SQR   = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int unsigned RAD_W = 56 + 2 * ((SQL + 1) / 2);
    localparam int unsigned RT_W  = RAD_W / 2;
    localparam int unsigned SQD   = RT_W;
    localparam int unsigned LAT   = SQD + 5;

    typedef struct packed {
        logic               dry;
        logic signed [31:0] ul;
        logic signed [31:0] ur;
        logic signed [31:0] hl;
        logic signed [31:0] hr;
    } t_item;

    logic [GRAV_W-1:0] r_grav;
    logic [LAT:0]      r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav <= GRAV_RESET;
            r_vld  <= '0;
        end else begin
            if (i_cfg_we) r_grav <= i_cfg_wdata;
            r_vld <= {r_vld[LAT-1:0], i_start};
        end
    end
    assign o_busy = 1'b0;

    // stage 1: gravity products
    t_item        r_it1;
    logic [55:0]  r_pl, r_pr;
    logic [30:0]  n_hlp, n_hrp;
    always_comb begin
        n_hlp = i_depth_left[31]  ? '0 : i_depth_left[30:0];
        n_hrp = i_depth_right[31] ? '0 : i_depth_right[30:0];
    end
    always_ff @(posedge i_clk) begin
        r_it1 <= '{dry: (i_depth_left <= 0) && (i_depth_right <= 0),
                   ul: i_vel_left, ur: i_vel_right, hl: i_depth_left, hr: i_depth_right};
        r_pl  <= 56'(r_grav) * 56'(n_hlp);
        r_pr  <= 56'(r_grav) * 56'(n_hrp);
    end

    logic [RAD_W-1:0] n_rl, n_rr;
    assign n_rl = (RAD_W'(r_pl) << SQL) >> SQR;
    assign n_rr = (RAD_W'(r_pr) << SQL) >> SQR;

    logic [RT_W-1:0] n_sl, n_sr;
    swrmf_isqrt #(.IN_W(RAD_W)) u_sql (.i_clk(i_clk), .i_rad(n_rl), .o_root(n_sl));
    swrmf_isqrt #(.IN_W(RAD_W)) u_sqr (.i_clk(i_clk), .i_rad(n_rr), .o_root(n_sr));

    // item delay matching the roots
    t_item r_dly [SQD];
    always_ff @(posedge i_clk) begin
        r_dly[0] <= r_it1;
        for (int k = 1; k < SQD; k++) r_dly[k] <= r_dly[k-1];
    end
    t_item it_s;
    assign it_s = r_dly[SQD-1];

    // stage A: wave speeds
    t_item        r_ita;
    logic [32:0]  r_cl, r_cr;
    always_ff @(posedge i_clk) begin
        r_ita <= it_s;
        r_cl  <= 33'($unsigned(it_s.ul[31] ? -it_s.ul : it_s.ul)) + 33'(n_sl);
        r_cr  <= 33'($unsigned(it_s.ur[31] ? -it_s.ur : it_s.ur)) + 33'(n_sr);
    end

    // stage B: max and difference
    t_item              r_itb;
    logic signed [33:0] r_c;
    logic signed [32:0] r_dh;
    always_ff @(posedge i_clk) begin
        r_itb <= r_ita;
        r_c   <= $signed({1'b0, (r_cl >= r_cr) ? r_cl : r_cr});
        r_dh  <= 33'(r_ita.hr) - 33'(r_ita.hl);
    end

    // stage C: three products
    logic               r_dryc;
    logic signed [63:0] r_ml, r_mr;
    logic signed [66:0] r_mc;
    always_ff @(posedge i_clk) begin
        r_dryc <= r_itb.dry;
        r_ml   <= r_itb.ul * r_itb.hl;
        r_mr   <= r_itb.ur * r_itb.hr;
        r_mc   <= r_c * r_dh;
    end

    // stage D: sum
    logic               r_dryd;
    logic signed [68:0] r_t;
    always_ff @(posedge i_clk) begin
        r_dryd <= r_dryc;
        r_t    <= 69'(r_ml) + 69'(r_mr) - 69'(r_mc) + (69'sd1 <<< FRAC_BITS);
    end

    // stage E: shift and saturate, or zero for a dry interface
    logic signed [68:0] n_sh;
    logic               n_hi, n_lo;
    assign n_sh = r_t >>> (FRAC_BITS + 1);
    assign n_hi = n_sh > 69'sh7FFF_FFFF_FFFF;
    assign n_lo = n_sh < -69'sh8000_0000_0000;

    logic [FLUX_W-1:0] r_flux;
    logic              r_sat;
    always_ff @(posedge i_clk) begin
        if (r_dryd) begin
            r_flux <= '0;
            r_sat  <= 1'b0;
        end else if (n_hi) begin
            r_flux <= {1'b0, {(FLUX_W-1){1'b1}}};
            r_sat  <= 1'b1;
        end else if (n_lo) begin
            r_flux <= {1'b1, {(FLUX_W-1){1'b0}}};
            r_sat  <= 1'b1;
        end else begin
            r_flux <= n_sh[FLUX_W-1:0];
            r_sat  <= 1'b0;
        end
    end

    assign o_done      = r_vld[LAT];
    assign o_mass_flux = r_flux;
    assign o_saturated = r_sat;

    a_sat_ext: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_saturated |-> (o_mass_flux[FLUX_W-2:0] == '0 ||
                                    o_mass_flux[FLUX_W-2:0] == '1))
        else $error("saturated flux not at a limit");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> ##(LAT) o_done)
        else $error("result strobe lost");
    a_dry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dryd |=> (r_flux == '0 && !r_sat))
        else $error("dry interface gave nonzero flux");
endmodule

// File: sim/shallow_water_rusanov_mass_flux_tb.sv
// Testbench for shallow_water_rusanov_mass_flux: directed table plus random interfaces,
// each flux checked against an in-bench fixed-point predictor. Depends on swrmf_pkg.
`timescale 1ns / 1ps
module shallow_water_rusanov_mass_flux_tb;
    import swrmf_pkg::*;

    localparam int unsigned FB      = 16;
    localparam int unsigned LATENCY = FB + 20;

    typedef struct {
        logic [VEL_W-1:0] ul, ur, hl, hr;
        logic             known;
        logic [FLUX_W-1:0] flux;
        logic             sat;
    } iface_row_t;

    typedef struct {
        logic [FLUX_W-1:0] flux;
        logic              sat;
    } flux_t;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic                     i_cfg_we;
    logic [GRAV_W-1:0]        i_cfg_wdata;
    logic signed [VEL_W-1:0]  i_vel_left;
    logic signed [VEL_W-1:0]  i_vel_right;
    logic signed [VEL_W-1:0]  i_depth_left;
    logic signed [VEL_W-1:0]  i_depth_right;
    logic                     o_done;
    logic signed [FLUX_W-1:0] o_mass_flux;
    logic                     o_saturated;

    logic [GRAV_W-1:0] grav_model;
    flux_t             flux_queue[$];
    int                n_errors;
    iface_row_t        dir_rows[$];

    shallow_water_rusanov_mass_flux #(.FRAC_BITS(FB)) DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("shallow_water_rusanov_mass_flux: mismatch");
        $finish;
    end

    function automatic logic [63:0] root_of(logic [63:0] x);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= x) r |= 64'd1 << b;
        end
        return r;
    endfunction

    function automatic logic [63:0] wave_root(logic signed [31:0] h);
        logic [63:0] p;
        p = (h > 0) ? 64'(grav_model) * 64'(h) : 64'd0;
        return root_of(p);
    endfunction

    function automatic flux_t rusanov_flux(logic signed [31:0] ul, logic signed [31:0] ur,
                                           logic signed [31:0] hl, logic signed [31:0] hr);
        flux_t r;
        logic signed [127:0] t, c, cl, cr;
        if (hl <= 0 && hr <= 0) begin
            r.flux = '0;
            r.sat  = 1'b0;
            return r;
        end
        cl = (ul < 0 ? -128'(ul) : 128'(ul)) + 128'(wave_root(hl));
        cr = (ur < 0 ? -128'(ur) : 128'(ur)) + 128'(wave_root(hr));
        c = (cl >= cr) ? cl : cr;
        t = 128'(ul) * 128'(hl) + 128'(ur) * 128'(hr) - c * (128'(hr) - 128'(hl));
        t = (t + (128'sd1 <<< FB)) >>> (FB + 1);
        if (t > 128'sd140737488355327) begin
            r.flux = 48'h7FFF_FFFF_FFFF;
            r.sat  = 1'b1;
        end else if (t < -128'sd140737488355328) begin
            r.flux = 48'h8000_0000_0000;
            r.sat  = 1'b1;
        end else begin
            r.flux = t[47:0];
            r.sat  = 1'b0;
        end
        return r;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t %s got %0h want %0h", $realtime, what, got, want);
        n_errors++;
    endtask

    always @(posedge i_clk) begin
        flux_t w;
        if (i_rst_n && o_done) begin
            if (flux_queue.size() == 0) begin
                report("unexpected transfer", 64'(o_mass_flux), 0);
            end else begin
                w = flux_queue.pop_front();
                if (o_mass_flux !== w.flux) report("mass_flux", 64'(o_mass_flux), 64'(w.flux));
                if (o_saturated !== w.sat) report("saturated", 64'(o_saturated), 64'(w.sat));
            end
        end
    end

    task automatic send(logic [31:0] ul, logic [31:0] ur, logic [31:0] hl, logic [31:0] hr,
                        bit known, flux_t want, bit idle_ok);
        flux_t p;
        while (idle_ok && $urandom_range(99) < 35) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start       <= 1'b1;
        i_vel_left    <= ul;
        i_vel_right   <= ur;
        i_depth_left  <= hl;
        i_depth_right <= hr;
        do @(posedge i_clk); while (o_busy);
        p = rusanov_flux(ul, ur, hl, hr);
        if (known && (p.flux !== want.flux || p.sat !== want.sat))
            report("table row", 64'(p.flux), 64'(want.flux));
        flux_queue.push_back(known ? want : p);
        @(negedge i_clk);
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (flux_queue.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic set_gravity(logic [GRAV_W-1:0] g);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= g;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        grav_model = g;
    endtask

    function automatic logic [31:0] rand_field(int kind);
        case (kind)
            0: return $urandom();
            1: return $urandom_range(32'h000F_FFFF);
            2: return -$urandom_range(32'h000F_FFFF);
            3: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(3)
                                        : 32'h8000_0000 + $urandom_range(3);
            default: return $urandom_range(32'h0000_FFFF);
        endcase
    endfunction

    task automatic random_phase(int n, bit idle_ok);
        flux_t none;
        none = '{default: '0};
        for (int k = 0; k < n; k++) begin
            send(rand_field($urandom_range(4)), rand_field($urandom_range(4)),
                 rand_field($urandom_range(4)), rand_field($urandom_range(4)), 0, none, idle_ok);
        end
    endtask

    initial begin
        flux_t want;
        n_errors      = 0;
        grav_model    = GRAV_RESET;
        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        i_vel_left    = '0;
        i_vel_right   = '0;
        i_depth_left  = '0;
        i_depth_right = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ul, ur, hl, hr, known, flux, sat
        dir_rows = '{
            '{32'h0, 32'h0, 32'h0, 32'h0, 1, 48'h0, 0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 1, 48'h0, 0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_0000, 32'h8000_0000, 1, 48'h0, 0},
            '{32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000, 1, 48'h0, 0},
            '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1, 48'h1_0000, 0},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 48'h0, 0},
            '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 48'h0, 0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 0, 48'h0, 0},
            '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 48'h0, 0},
            '{32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 0, 48'h0, 0},
            '{32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 0, 48'h0, 0},
            '{32'hFFFF_0000, 32'h0002_0000, 32'h0003_0000, 32'hFFFE_0000, 0, 48'h0, 0},
            '{32'h0000_8000, 32'hFFFF_8000, 32'h0000_0001, 32'h0000_0001, 0, 48'h0, 0},
            '{32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 0, 48'h0, 0},
            '{32'h1234_5678, 32'hEDCB_A987, 32'h0100_0000, 32'h0000_0100, 0, 48'h0, 0}
        };
        foreach (dir_rows[k]) begin
            want.flux = dir_rows[k].flux;
            want.sat  = dir_rows[k].sat;
            send(dir_rows[k].ul, dir_rows[k].ur, dir_rows[k].hl, dir_rows[k].hr,
                 dir_rows[k].known, want, 0);
        end

        random_phase(250, 1);
        set_gravity(24'hFF_FFFF);
        random_phase(150, 0);
        set_gravity(24'h0);
        random_phase(100, 1);
        set_gravity(24'h0_0001);
        random_phase(100, 1);
        set_gravity(24'($urandom_range(24'hFF_FFFF)));
        random_phase(235, 1);
        drain();

        if (n_errors == 0) begin
            $display("shallow_water_rusanov_mass_flux: match");
        end else begin
            $display("shallow_water_rusanov_mass_flux: mismatch");
        end
        $finish;
    end
endmodule

// File: shallow_water_rusanov_mass_flux.f
design/swrmf_pkg.sv
design/swrmf_isqrt.sv
design/shallow_water_rusanov_mass_flux.sv
sim/shallow_water_rusanov_mass_flux_tb.sv
